/* design/ocft_pkg.sv */
// shared types, register indexes and event bit positions for the over-current fast trip
package ocft_pkg;

   localparam int CURRENT_W = 16;
   localparam int LEVEL_W   = 15;
   localparam int COUNT_W   = 16;
   localparam int EVENT_W   = 10;
   localparam int ADC_PHASES = 3;

   // event mask bit positions
   localparam int EV_CROSS    = 0;
   localparam int EV_ASSERT   = 1;
   localparam int EV_CLEAR    = 2;
   localparam int EV_LATCH    = 3;
   localparam int EV_INHIBIT  = 4;
   localparam int EV_GATESOFF = 5;
   localparam int EV_OBSERVED = 6;
   localparam int EV_CLEARED  = 7;
   localparam int EV_REARMED  = 8;
   localparam int EV_INVALID  = 9;

   typedef enum logic [2:0] {
      CSR_TRIP_ENABLE    = 3'd0,
      CSR_TRIP_THRESHOLD = 3'd1,
      CSR_HYSTERESIS     = 3'd2,
      CSR_BREAK_DELAY    = 3'd3,
      CSR_GATE_OFF_DELAY = 3'd4,
      CSR_BLANK_START    = 3'd5,
      CSR_BLANK_LENGTH   = 3'd6,
      CSR_RESET_HOLD     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               trip_enable;
      logic [LEVEL_W-1:0] trip_threshold;
      logic [LEVEL_W-1:0] hysteresis;
      logic [COUNT_W-1:0] break_wait;
      logic [COUNT_W-1:0] gate_off_wait;
      logic [COUNT_W-1:0] blank_start;
      logic [COUNT_W-1:0] blank_length;
      logic [COUNT_W-1:0] clear_hold;
   } cfg_type;

   // clear level of a window; valid low when threshold minus hysteresis is negative
   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
   } low_level_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   pwm_phase;
      logic                 sample_valid;
      logic                 gate_request;
      logic                 clear_request;
      logic                 drive_disabled;
      logic                 rearm_request;
      logic                 drive_ready;
      logic                 supervisor_ack;
      logic                 any_window;
      logic [CURRENT_W-1:0] peak;
   } tick_type;

   typedef struct packed {
      logic                 gate_enable;
      logic                 trip_latched;
      logic                 gates_forced_off;
      logic                 comparator_out;
      logic                 overcurrent_raw;
      logic                 restart_hold;
      logic                 trip_observed;
      logic [CURRENT_W-1:0] peak_magnitude;
      logic [COUNT_W-1:0]   episode_count;
      logic [EVENT_W-1:0]   event_mask;
   } result_type;

   function automatic logic [CURRENT_W-1:0] abs_mag(input logic signed [CURRENT_W-1:0] x);
      logic [CURRENT_W-1:0] neg;
      neg = CURRENT_W'(-x);
      return x[CURRENT_W-1] ? neg : CURRENT_W'(x);
   endfunction

endpackage

/* design/ocft_phase_lane.sv */
// one phase lane: magnitude and hysteresis window for a single phase current
module ocft_phase_lane import ocft_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        update,
   input  logic signed [CURRENT_W-1:0] current,
   input  logic [LEVEL_W-1:0]          threshold,
   input  low_level_type               low,
   output logic [CURRENT_W-1:0]        magnitude,
   output logic                        window_next
);

   logic window_ff;
   logic window_in;

   always_comb begin
      magnitude = abs_mag(current);
      window_in = window_ff;
      if (magnitude >= {1'b0, threshold}) begin
         window_in = 1'b1;
      end else if (low.valid && magnitude <= {1'b0, low.level}) begin
         window_in = 1'b0;
      end
      window_next = window_in;
   end

   // window only moves on a valid, enabled tick
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 1'b0;
      end else if (update) begin
         window_ff <= window_in;
      end
   end

endmodule

/* design/ocft_trip_ctrl.sv */
// trip sequencer: inertial delay, break delay, latch, gate-off, clear and rearm
module ocft_trip_ctrl import ocft_pkg::*; #(
   parameter int PROPAGATION_TICKS = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  cfg_type       cfg,
   input  low_level_type low,
   input  tick_type      tick,
   output result_type    result
);

   localparam int PW = (PROPAGATION_TICKS > 0) ? $clog2(PROPAGATION_TICKS + 1) : 1;

   logic               raw_ff, raw_in;
   logic               comp_ff, comp_in;
   logic               pend_ff, pend_in;
   logic               prop_on_ff, prop_on_in;
   logic [PW-1:0]      prop_cnt_ff, prop_cnt_in;
   logic               brk_on_ff, brk_on_in;
   logic [COUNT_W-1:0] brk_cnt_ff, brk_cnt_in;
   logic               goff_on_ff, goff_on_in;
   logic [COUNT_W-1:0] goff_cnt_ff, goff_cnt_in;
   logic               latched_ff, latched_in;
   logic               observed_ff, observed_in;
   logic               gates_dropped_ff, gates_dropped_in;
   logic               restart_ff, restart_in;
   logic               low_seen_ff, low_seen_in;
   logic               req_at_trip_ff, req_at_trip_in;
   logic               last_req_ff, last_req_in;
   logic               safe_on_ff, safe_on_in;
   logic [COUNT_W-1:0] safe_cnt_ff, safe_cnt_in;
   logic [COUNT_W-1:0] episode_ff, episode_in;

   logic               blanked;
   logic               peak_low;
   logic               fresh;
   logic               gate_en;
   logic [EVENT_W-1:0] ev;

   always_comb begin
      blanked = (cfg.blank_length != '0) && (tick.pwm_phase >= cfg.blank_start) &&
                ({1'b0, tick.pwm_phase} <
                 ({1'b0, cfg.blank_start} + {1'b0, cfg.blank_length}));
      peak_low = low.valid && (tick.peak <= {1'b0, low.level});
   end

   always_comb begin
      ev               = '0;
      fresh            = 1'b0;
      raw_in           = raw_ff;
      comp_in          = comp_ff;
      pend_in          = pend_ff;
      prop_on_in       = prop_on_ff;
      prop_cnt_in      = prop_cnt_ff;
      brk_on_in        = brk_on_ff;
      brk_cnt_in       = brk_cnt_ff;
      goff_on_in       = goff_on_ff;
      goff_cnt_in      = goff_cnt_ff;
      latched_in       = latched_ff;
      observed_in      = observed_ff;
      gates_dropped_in = gates_dropped_ff;
      restart_in       = restart_ff;
      low_seen_in      = low_seen_ff;
      req_at_trip_in   = req_at_trip_ff;
      last_req_in      = last_req_ff;
      safe_on_in       = safe_on_ff;
      safe_cnt_in      = safe_cnt_ff;
      episode_in       = episode_ff;

      if (cfg.trip_enable) begin
         if (prop_on_in && prop_cnt_in != '0) prop_cnt_in = prop_cnt_in - 1'b1;
         if (brk_on_in && brk_cnt_in != '0) brk_cnt_in = brk_cnt_in - 1'b1;
         if (goff_on_in && goff_cnt_in != '0) goff_cnt_in = goff_cnt_in - 1'b1;

         if (!tick.sample_valid) begin
            // fail closed: latch and drop the gates in the same tick
            safe_on_in = 1'b0;
            prop_on_in = 1'b0;
            brk_on_in  = 1'b0;
            if (!latched_in) begin
               ev[EV_INVALID]  = 1'b1;
               ev[EV_LATCH]    = 1'b1;
               ev[EV_INHIBIT]  = 1'b1;
               latched_in      = 1'b1;
               observed_in     = 1'b0;
               req_at_trip_in  = last_req_in;
               episode_in      = episode_in + 1'b1;
               goff_on_in      = 1'b1;
               goff_cnt_in     = '0;
            end
            if (!gates_dropped_in) ev[EV_GATESOFF] = 1'b1;
            gates_dropped_in = 1'b1;
            goff_on_in       = 1'b0;
         end else begin
            raw_in = tick.any_window;
            if (raw_in && !raw_ff) ev[EV_CROSS] = 1'b1;

            // inertial delay: a level change restarts the countdown
            if (raw_in == comp_in) begin
               prop_on_in = 1'b0;
            end else if (!prop_on_in || pend_in != raw_in) begin
               pend_in     = raw_in;
               prop_on_in  = 1'b1;
               prop_cnt_in = PW'(PROPAGATION_TICKS);
            end
            if (prop_on_in && prop_cnt_in == '0) begin
               comp_in    = pend_in;
               prop_on_in = 1'b0;
               if (comp_in) ev[EV_ASSERT] = 1'b1;
               else         ev[EV_CLEAR]  = 1'b1;
            end

            if (!latched_in && comp_in && !blanked && !brk_on_in) begin
               brk_on_in  = 1'b1;
               brk_cnt_in = cfg.break_wait;
            end
            if (brk_on_in && brk_cnt_in == '0) begin
               brk_on_in = 1'b0;
               if (!latched_in) begin
                  ev[EV_LATCH]   = 1'b1;
                  ev[EV_INHIBIT] = 1'b1;
                  latched_in     = 1'b1;
                  observed_in    = 1'b0;
                  req_at_trip_in = last_req_in;
                  episode_in     = episode_in + 1'b1;
                  goff_on_in     = 1'b1;
                  goff_cnt_in    = cfg.gate_off_wait;
               end
            end
            if (goff_on_in && goff_cnt_in == '0) begin
               gates_dropped_in = 1'b1;
               goff_on_in       = 1'b0;
               ev[EV_GATESOFF]  = 1'b1;
            end

            if (!raw_in && !comp_in && peak_low) begin
               if (!safe_on_in) begin
                  safe_on_in  = 1'b1;
                  safe_cnt_in = '0;
               end else if (safe_cnt_in != '1) begin
                  safe_cnt_in = safe_cnt_in + 1'b1;
               end
            end else begin
               safe_on_in = 1'b0;
            end
         end
      end

      if (tick.supervisor_ack && latched_in && !observed_in) begin
         observed_in     = 1'b1;
         ev[EV_OBSERVED] = 1'b1;
      end

      if (cfg.trip_enable && latched_in && gates_dropped_in && tick.drive_disabled &&
          tick.clear_request && tick.sample_valid && !raw_in && !comp_in && !blanked &&
          safe_on_in && safe_cnt_in >= cfg.clear_hold) begin
         latched_in     = 1'b0;
         restart_in     = 1'b1;
         low_seen_in    = 1'b0;
         ev[EV_CLEARED] = 1'b1;
      end

      // rearm wants a low level seen before the high one
      if (cfg.trip_enable && restart_in && !latched_in) begin
         if (!tick.rearm_request) begin
            low_seen_in = 1'b1;
         end else begin
            fresh       = low_seen_in;
            low_seen_in = 1'b0;
            if (fresh && tick.drive_ready && tick.sample_valid && !raw_in && !comp_in &&
                !blanked) begin
               restart_in       = 1'b0;
               gates_dropped_in = 1'b0;
               last_req_in      = 1'b0;
               ev[EV_REARMED]   = 1'b1;
            end
         end
      end

      if (gates_dropped_in) begin
         gate_en = 1'b0;
      end else if (latched_in) begin
         gate_en = req_at_trip_in;
      end else begin
         last_req_in = tick.gate_request;
         gate_en     = tick.gate_request;
      end

      result.gate_enable      = gate_en;
      result.trip_latched     = latched_in;
      result.gates_forced_off = gates_dropped_in;
      result.comparator_out   = comp_in;
      result.overcurrent_raw  = raw_in;
      result.restart_hold     = restart_in;
      result.trip_observed    = observed_in;
      result.peak_magnitude   = tick.sample_valid ? tick.peak : '0;
      result.episode_count    = episode_in;
      result.event_mask       = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff           <= 1'b0;
         comp_ff          <= 1'b0;
         pend_ff          <= 1'b0;
         prop_on_ff       <= 1'b0;
         prop_cnt_ff      <= '0;
         brk_on_ff        <= 1'b0;
         brk_cnt_ff       <= '0;
         goff_on_ff       <= 1'b0;
         goff_cnt_ff      <= '0;
         latched_ff       <= 1'b0;
         observed_ff      <= 1'b0;
         gates_dropped_ff <= 1'b0;
         restart_ff       <= 1'b0;
         low_seen_ff      <= 1'b0;
         req_at_trip_ff   <= 1'b0;
         last_req_ff      <= 1'b0;
         safe_on_ff       <= 1'b0;
         safe_cnt_ff      <= '0;
         episode_ff       <= '0;
      end else if (step) begin
         raw_ff           <= raw_in;
         comp_ff          <= comp_in;
         pend_ff          <= pend_in;
         prop_on_ff       <= prop_on_in;
         prop_cnt_ff      <= prop_cnt_in;
         brk_on_ff        <= brk_on_in;
         brk_cnt_ff       <= brk_cnt_in;
         goff_on_ff       <= goff_on_in;
         goff_cnt_ff      <= goff_cnt_in;
         latched_ff       <= latched_in;
         observed_ff      <= observed_in;
         gates_dropped_ff <= gates_dropped_in;
         restart_ff       <= restart_in;
         low_seen_ff      <= low_seen_in;
         req_at_trip_ff   <= req_at_trip_in;
         last_req_ff      <= last_req_in;
         safe_on_ff       <= safe_on_in;
         safe_cnt_ff      <= safe_cnt_in;
         episode_ff       <= episode_in;
      end
   end

   // a new latch counts exactly one episode
   a_episode_on_latch: assert property (@(posedge clock) disable iff (reset)
      step && !latched_ff && latched_in |-> episode_in == episode_ff + 1'b1)
      else $error("episode count did not advance on latch");

   // gates only come back through a rearm, so unlatched with gates off means restart hold
   a_gates_dropped_needs_restart: assert property (@(posedge clock) disable iff (reset)
      gates_dropped_ff && !latched_ff |-> restart_ff)
      else $error("gates off while unlatched without restart hold");

   // protection disabled freezes the comparator path
   a_disabled_frozen: assert property (@(posedge clock) disable iff (reset)
      step && !reset && !cfg.trip_enable |=>
         raw_ff == $past(raw_ff) && comp_ff == $past(comp_ff))
      else $error("comparator path moved while protection disabled");

endmodule

/* design/overcurrent_fast_trip_unit.sv */
// top level of the three-phase over-current fast trip with break latch
//
//  channel   ports          dir  payload
//  ------------------------------------------------------------------------------
//  sample    req_t*         in   currents a/b/c, pwm phase, valid, control requests
//  result    rsp_t*         out  gate/latch status, peak magnitude, episodes, events
//  config    csr_*          in   write-only register file, 8 registers
//
//  one sample is accepted per clock while no stalled result is held; its result
//  appears in the output register on the next cycle, set by the trip sequencer update.
//  the phase lanes and the sequencer state advance only on an accepted transfer.
//  a stalled result holds while the next sample may still be taken as it leaves.
//  synchronous reset returns all protection state to idle, unlatched and gates on.
module overcurrent_fast_trip_unit import ocft_pkg::*; #(
   parameter int PROPAGATION_TICKS = 2,
   parameter int PHASE_COUNT       = 3
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, lowest bit up: current_a[15:0], current_b[15:0], current_c[15:0],
   // pwm_phase[15:0], sample_valid, gate_request, clear_request, drive_disabled,
   // rearm_request, drive_ready, supervisor_ack, one zero pad bit
   input  logic [71:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata, lowest bit up: gate_enable, trip_latched, gates_forced_off,
   // comparator_out, overcurrent_raw, restart_hold, trip_observed,
   // peak_magnitude[15:0], episode_count[15:0], event_mask[9:0], 7 zero pad bits
   output logic [55:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LANE_COUNT = (PHASE_COUNT > ADC_PHASES) ? PHASE_COUNT : ADC_PHASES;

   cfg_type       cfg_ff;
   low_level_type low;
   tick_type      tick;
   result_type    result;
   result_type    rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          lane_update;

   logic signed [CURRENT_W-1:0] adc_current [ADC_PHASES];
   logic [CURRENT_W-1:0]        lane_mag    [LANE_COUNT];
   logic [LANE_COUNT-1:0]       lane_window;
   logic                        any_window;
   logic [CURRENT_W-1:0]        peak;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_enable    <= 1'b0;
         cfg_ff.trip_threshold <= '1;
         cfg_ff.hysteresis     <= '0;
         cfg_ff.break_wait     <= '0;
         cfg_ff.gate_off_wait  <= '0;
         cfg_ff.blank_start    <= '0;
         cfg_ff.blank_length   <= '0;
         cfg_ff.clear_hold     <= '0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIP_ENABLE:    cfg_ff.trip_enable    <= csr_wdata[0];
            CSR_TRIP_THRESHOLD: cfg_ff.trip_threshold <= csr_wdata[LEVEL_W-1:0];
            CSR_HYSTERESIS:     cfg_ff.hysteresis     <= csr_wdata[LEVEL_W-1:0];
            CSR_BREAK_DELAY:    cfg_ff.break_wait     <= csr_wdata;
            CSR_GATE_OFF_DELAY: cfg_ff.gate_off_wait  <= csr_wdata;
            CSR_BLANK_START:    cfg_ff.blank_start    <= csr_wdata;
            CSR_BLANK_LENGTH:   cfg_ff.blank_length   <= csr_wdata;
            CSR_RESET_HOLD:     cfg_ff.clear_hold     <= csr_wdata;
         endcase
      end
   end

   // a negative clear level means a window never clears
   always_comb begin
      low.valid = cfg_ff.hysteresis <= cfg_ff.trip_threshold;
      low.level = cfg_ff.trip_threshold - cfg_ff.hysteresis;
   end

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   // windows move on enabled valid ticks only
   assign lane_update = accept && cfg_ff.trip_enable && req_tdata[64];

   assign adc_current[0] = req_tdata[15:0];
   assign adc_current[1] = req_tdata[31:16];
   assign adc_current[2] = req_tdata[47:32];

   for (genvar n = 0; n < LANE_COUNT; n++) begin : g_lane
      logic signed [CURRENT_W-1:0] lane_current;
      logic                        lane_next;
      if (n < ADC_PHASES) begin : g_adc
         assign lane_current = adc_current[n];
      end else begin : g_idle
         assign lane_current = '0;
      end
      ocft_phase_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .update      (lane_update),
         .current     (lane_current),
         .threshold   (cfg_ff.trip_threshold),
         .low         (low),
         .magnitude   (lane_mag[n]),
         .window_next (lane_next)
      );
      assign lane_window[n] = lane_next;
   end

   // merge: OR of the live windows, peak over the measured phases
   always_comb begin
      any_window = 1'b0;
      for (int n = 0; n < LANE_COUNT; n++) begin
         if (n < PHASE_COUNT) any_window = any_window | lane_window[n];
      end
      peak = '0;
      for (int n = 0; n < ADC_PHASES; n++) begin
         if (lane_mag[n] > peak) peak = lane_mag[n];
      end
   end

   always_comb begin
      tick.pwm_phase      = req_tdata[63:48];
      tick.sample_valid   = req_tdata[64];
      tick.gate_request   = req_tdata[65];
      tick.clear_request  = req_tdata[66];
      tick.drive_disabled = req_tdata[67];
      tick.rearm_request  = req_tdata[68];
      tick.drive_ready    = req_tdata[69];
      tick.supervisor_ack = req_tdata[70];
      tick.any_window     = any_window;
      tick.peak           = peak;
   end

   ocft_trip_ctrl #(
      .PROPAGATION_TICKS (PROPAGATION_TICKS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .cfg    (cfg_ff),
      .low    (low),
      .tick   (tick),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_ff.event_mask,
                        rsp_ff.episode_count,
                        rsp_ff.peak_magnitude,
                        rsp_ff.trip_observed,
                        rsp_ff.restart_hold,
                        rsp_ff.overcurrent_raw,
                        rsp_ff.comparator_out,
                        rsp_ff.gates_forced_off,
                        rsp_ff.trip_latched,
                        rsp_ff.gate_enable};

   // protection masking always wins over the held gate request
   a_gates_dropped_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.gates_forced_off |-> !rsp_ff.gate_enable)
      else $error("gate enabled while gates forced off");

   // an invalid sample under enabled protection must report gates off
   a_invalid_trips: assert property (@(posedge clock) disable iff (reset)
      accept && cfg_ff.trip_enable && !req_tdata[64] |=>
         rsp_ff.trip_latched && rsp_ff.gates_forced_off && rsp_ff.peak_magnitude == '0)
      else $error("invalid sample did not trip");

endmodule

/* tb/sv/ocft_trip_scoreboard.sv */
// sample layout and trip predictor scoreboard for the over-current fast trip testbench
`timescale 1ns / 1ps

package ocft_tb_pkg;
   import ocft_pkg::*;

   localparam int unsigned PROP_TICKS = 2;

   // packed so that current_a lands in the lowest bits of req_tdata
   typedef struct packed {
      logic                 pad;
      logic                 supervisor_ack;
      logic                 drive_ready;
      logic                 rearm_request;
      logic                 drive_disabled;
      logic                 clear_request;
      logic                 gate_request;
      logic                 sample_valid;
      logic [15:0]          pwm_phase;
      logic signed [15:0]   current_c;
      logic signed [15:0]   current_b;
      logic signed [15:0]   current_a;
   } trip_sample_type;

   class trip_scoreboard;
      // register copy
      bit          enable;
      int unsigned threshold = 32767;
      int unsigned hyst;
      int unsigned break_ticks;
      int unsigned gate_off_ticks;
      int unsigned blank_from;
      int unsigned blank_len;
      int unsigned hold_ticks;

      // protection state
      bit          window[3];
      bit          raw, cmp_level, pend_level;
      bit          prop_on, brk_on, goff_on;
      int unsigned prop_cnt, brk_cnt, goff_cnt;
      bit          latched, observed, gates_dropped, restart, low_seen;
      bit          req_at_trip, last_req;
      bit          safe_on;
      int unsigned safe_cnt;
      bit [15:0]   episodes;
      bit [9:0]    ev;

      result_type  trip_results_q[$];
      int          errors;

      function void set_register(csr_index_type idx, logic [15:0] v);
         case (idx)
            CSR_TRIP_ENABLE:    enable = v[0];
            CSR_TRIP_THRESHOLD: threshold = v[14:0];
            CSR_HYSTERESIS:     hyst = v[14:0];
            CSR_BREAK_DELAY:    break_ticks = v;
            CSR_GATE_OFF_DELAY: gate_off_ticks = v;
            CSR_BLANK_START:    blank_from = v;
            CSR_BLANK_LENGTH:   blank_len = v;
            CSR_RESET_HOLD:     hold_ticks = v;
            default: ;
         endcase
      endfunction

      function int pending();
         return trip_results_q.size();
      endfunction

      function bit blanked(int unsigned ph);
         // window end is taken without 16-bit wrap
         return blank_len != 0 && ph >= blank_from && ph < blank_from + blank_len;
      endfunction

      function void set_latch(bit from_invalid);
         if (latched) return;
         latched = 1;
         observed = 0;
         req_at_trip = last_req;
         episodes++;
         ev[EV_LATCH] = 1;
         ev[EV_INHIBIT] = 1;
         brk_on = 0;
         goff_on = 1;
         goff_cnt = from_invalid ? 0 : gate_off_ticks;
      endfunction

      function void note_sample(trip_sample_type s);
         logic signed [15:0] cur[3];
         int          mag[3];
         int          peak_mag;
         int          low_lvl;
         int          x;
         int unsigned ph;
         bit          valid, any_hot, old_raw, gate_en;
         result_type  r;
         cur = '{s.current_a, s.current_b, s.current_c};
         peak_mag = 0;
         low_lvl = int'(threshold) - int'(hyst);
         ph = s.pwm_phase;
         valid = s.sample_valid;
         ev = '0;
         for (int n = 0; n < 3; n++) begin
            x = cur[n];
            mag[n] = x < 0 ? -x : x;
            if (mag[n] > peak_mag) peak_mag = mag[n];
         end
         if (!valid) peak_mag = 0;

         if (enable) begin
            if (prop_on && prop_cnt > 0) prop_cnt--;
            if (brk_on && brk_cnt > 0) brk_cnt--;
            if (goff_on && goff_cnt > 0) goff_cnt--;
            if (!valid) begin
               // fail closed: latch and gates off at once, windows hold
               safe_on = 0;
               prop_on = 0;
               brk_on = 0;
               if (!latched) begin
                  ev[EV_INVALID] = 1;
                  set_latch(1);
               end
               if (!gates_dropped) ev[EV_GATESOFF] = 1;
               gates_dropped = 1;
               goff_on = 0;
            end else begin
               old_raw = raw;
               any_hot = 0;
               for (int n = 0; n < 3; n++) begin
                  if (mag[n] >= int'(threshold)) window[n] = 1;
                  else if (mag[n] <= low_lvl) window[n] = 0;
                  if (window[n]) any_hot = 1;
               end
               raw = any_hot;
               if (raw && !old_raw) ev[EV_CROSS] = 1;

               // inertial delay toward the comparator
               if (raw == cmp_level) begin
                  prop_on = 0;
               end else if (!prop_on || pend_level != raw) begin
                  pend_level = raw;
                  prop_on = 1;
                  prop_cnt = PROP_TICKS;
               end
               if (prop_on && prop_cnt == 0) begin
                  cmp_level = pend_level;
                  prop_on = 0;
                  if (cmp_level) ev[EV_ASSERT] = 1;
                  else ev[EV_CLEAR] = 1;
               end

               if (!latched && cmp_level && !blanked(ph) && !brk_on) begin
                  brk_on = 1;
                  brk_cnt = break_ticks;
               end
               if (brk_on && brk_cnt == 0) begin
                  brk_on = 0;
                  set_latch(0);
               end
               if (goff_on && goff_cnt == 0) begin
                  gates_dropped = 1;
                  goff_on = 0;
                  ev[EV_GATESOFF] = 1;
               end

               if (!raw && !cmp_level && peak_mag <= low_lvl) begin
                  if (!safe_on) begin
                     safe_on = 1;
                     safe_cnt = 0;
                  end else if (safe_cnt < 65535) begin
                     safe_cnt++;
                  end
               end else begin
                  safe_on = 0;
               end
            end
         end

         if (s.supervisor_ack && latched && !observed) begin
            observed = 1;
            ev[EV_OBSERVED] = 1;
         end

         if (enable && latched && gates_dropped && s.drive_disabled && s.clear_request &&
             valid && !raw && !cmp_level && !blanked(ph) && safe_on &&
             safe_cnt >= hold_ticks) begin
            latched = 0;
            restart = 1;
            low_seen = 0;
            ev[EV_CLEARED] = 1;
         end

         // rearm wants a low level seen before the high one
         if (enable && restart && !latched) begin
            if (!s.rearm_request) begin
               low_seen = 1;
            end else begin
               if (low_seen && s.drive_ready && valid && !raw && !cmp_level && !blanked(ph)) begin
                  restart = 0;
                  gates_dropped = 0;
                  last_req = 0;
                  ev[EV_REARMED] = 1;
               end
               low_seen = 0;
            end
         end

         if (gates_dropped) begin
            gate_en = 0;
         end else if (latched) begin
            gate_en = req_at_trip;
         end else begin
            last_req = s.gate_request;
            gate_en = s.gate_request;
         end

         r.gate_enable      = gate_en;
         r.trip_latched     = latched;
         r.gates_forced_off = gates_dropped;
         r.comparator_out   = cmp_level;
         r.overcurrent_raw  = raw;
         r.restart_hold     = restart;
         r.trip_observed    = observed;
         r.peak_magnitude   = 16'(peak_mag);
         r.episode_count    = episodes;
         r.event_mask       = ev;
         trip_results_q = {trip_results_q, r};
      endfunction

      function void field_check(string name, int unsigned want, int unsigned have);
         if (want == have) return;
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, have);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (trip_results_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, expected none got %h", $time, got);
            return;
         end
         want = trip_results_q.pop_front();
         field_check("gate_enable", want.gate_enable, got.gate_enable);
         field_check("trip_latched", want.trip_latched, got.trip_latched);
         field_check("gates_forced_off", want.gates_forced_off, got.gates_forced_off);
         field_check("comparator_out", want.comparator_out, got.comparator_out);
         field_check("overcurrent_raw", want.overcurrent_raw, got.overcurrent_raw);
         field_check("restart_hold", want.restart_hold, got.restart_hold);
         field_check("trip_observed", want.trip_observed, got.trip_observed);
         field_check("peak_magnitude", want.peak_magnitude, got.peak_magnitude);
         field_check("episode_count", want.episode_count, got.episode_count);
         field_check("event_mask", want.event_mask, got.event_mask);
      endfunction
   endclass

endpackage

/* tb/sv/overcurrent_fast_trip_unit_tb.sv */
// testbench top for the over-current fast trip: directed and random samples checked per tick
`timescale 1ns / 1ps

module overcurrent_fast_trip_unit_tb;
   import ocft_pkg::*;
   import ocft_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   trip_sample_type req_sample = '0;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [55:0]     rsp_tdata;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic            csr_wen = 1'b0;
   logic [2:0]      csr_index = '0;
   logic [15:0]     csr_wdata = '0;

   trip_scoreboard  sb;
   cfg_type         active_cfg;
   int              send_idle_pct = 21;
   int              recv_idle_pct = 58;
   int              cycle_count = 0;

   overcurrent_fast_trip_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_sample),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // both channels are sampled at the rising edge
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_sample);
         if (rsp_tvalid && rsp_tready) begin
            got.gate_enable      = rsp_tdata[0];
            got.trip_latched     = rsp_tdata[1];
            got.gates_forced_off = rsp_tdata[2];
            got.comparator_out   = rsp_tdata[3];
            got.overcurrent_raw  = rsp_tdata[4];
            got.restart_hold     = rsp_tdata[5];
            got.trip_observed    = rsp_tdata[6];
            got.peak_magnitude   = rsp_tdata[22:7];
            got.episode_count    = rsp_tdata[38:23];
            got.event_mask       = rsp_tdata[48:39];
            sb.check_result(got);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("overcurrent_fast_trip_unit_tb: errors");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_sample(input trip_sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_sample <= s;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // registers change only with no result outstanding
   task automatic apply_settings(input cfg_type c);
      csr_index_type idx;
      logic [15:0]   v;
      wait_drained();
      for (int i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_TRIP_ENABLE:    v = {15'd0, c.trip_enable};
            CSR_TRIP_THRESHOLD: v = {1'b0, c.trip_threshold};
            CSR_HYSTERESIS:     v = {1'b0, c.hysteresis};
            CSR_BREAK_DELAY:    v = c.break_wait;
            CSR_GATE_OFF_DELAY: v = c.gate_off_wait;
            CSR_BLANK_START:    v = c.blank_start;
            CSR_BLANK_LENGTH:   v = c.blank_length;
            default:            v = c.clear_hold;
         endcase
         csr_wen <= 1'b1;
         csr_index <= idx;
         csr_wdata <= v;
         sb.set_register(idx, v);
         @(negedge clock);
      end
      csr_wen <= 1'b0;
      active_cfg = c;
   endtask

   function automatic trip_sample_type mk(input int ia, input int ib, input int ic,
                                          input logic [15:0] ph, input bit valid,
                                          input bit gate, input bit clr, input bit dis,
                                          input bit rearm, input bit ready, input bit ack);
      trip_sample_type s;
      s = '0;
      s.current_a = 16'(ia);
      s.current_b = 16'(ib);
      s.current_c = 16'(ic);
      s.pwm_phase = ph;
      s.sample_valid = valid;
      s.gate_request = gate;
      s.clear_request = clr;
      s.drive_disabled = dis;
      s.rearm_request = rearm;
      s.drive_ready = ready;
      s.supervisor_ack = ack;
      return s;
   endfunction

   function automatic trip_sample_type random_sample(input bit hot);
      trip_sample_type s;
      int thr, low_lvl, quiet_max, mag[3], hot_phase;
      thr = active_cfg.trip_threshold;
      low_lvl = thr - int'(active_cfg.hysteresis);
      quiet_max = low_lvl < thr - 1 ? low_lvl : thr - 1;
      if (quiet_max < 0) quiet_max = thr - 1;
      hot_phase = $urandom_range(2);
      for (int n = 0; n < 3; n++) begin
         if (hot && n == hot_phase)
            mag[n] = thr + $urandom_range(0, (32768 - thr) < 300 ? 32768 - thr : 300);
         else if ($urandom_range(5) == 0)
            mag[n] = $urandom_range(quiet_max, thr - 1);  // inside the hysteresis band
         else
            mag[n] = $urandom_range(0, quiet_max);
         if ($urandom_range(1)) mag[n] = -mag[n];
      end
      s = mk(mag[0], mag[1], mag[2], 16'($urandom),
             $urandom_range(99) >= 3, $urandom_range(3) != 0, $urandom_range(1),
             $urandom_range(3) != 0, $urandom_range(1), $urandom_range(4) != 0,
             $urandom_range(4) == 0);
      // half the ticks land around the blanking window
      if ($urandom_range(1))
         s.pwm_phase = 16'(active_cfg.blank_start +
                           $urandom_range(0, active_cfg.blank_length + 2) - 1);
      return s;
   endfunction

   // bursts of over-current between quiet stretches, with some pure noise
   task automatic run_random(input int count);
      int              hot_left;
      int              quiet_left;
      bit              hot;
      trip_sample_type s;
      hot_left = 0;
      quiet_left = $urandom_range(2, 10);
      for (int i = 0; i < count; i++) begin
         if (hot_left == 0 && quiet_left == 0) begin
            hot_left = $urandom_range(1, 6);
            quiet_left = $urandom_range(2, 14);
         end
         if (hot_left > 0) begin
            hot = 1'b1;
            hot_left--;
         end else begin
            hot = 1'b0;
            quiet_left--;
         end
         if ($urandom_range(19) == 0) begin
            s = 72'({$urandom, $urandom, $urandom});
            s.pad = 1'b0;
         end else begin
            s = random_sample(hot);
         end
         send_sample(s);
      end
   endtask

   initial begin
      sb = new();
      active_cfg = '{1'b0, 15'd32767, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: protection off, peak still reported
      send_sample(mk(-32768, 32767, 5, 16'hFFFF, 1, 1, 0, 0, 0, 0, 0));
      send_sample(mk(0, 0, 0, 16'h0000, 0, 1, 1, 1, 1, 1, 1));

      // fields: enable, threshold, hysteresis, break, gate-off, blank start, blank length, hold
      apply_settings('{1'b1, 15'd1000, 15'd100, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0});
      send_sample(mk(10, -20, 30, 16'd0, 1, 1, 0, 0, 0, 1, 0));
      send_sample(mk(0, -32768, 0, 16'd1, 1, 1, 0, 0, 0, 1, 0));     // one-tick pulse
      send_sample(mk(5, 5, 5, 16'd2, 1, 1, 0, 0, 0, 1, 0));          // pulse rejected
      send_sample(mk(1000, 0, 0, 16'd3, 1, 1, 0, 0, 0, 1, 0));       // exactly threshold
      send_sample(mk(950, 0, 0, 16'd4, 1, 1, 0, 0, 0, 1, 0));        // band holds window
      send_sample(mk(32767, 0, 0, 16'd5, 1, 0, 0, 0, 0, 1, 0));      // latch, request held
      send_sample(mk(900, 0, 0, 16'd6, 1, 0, 0, 0, 0, 1, 1));        // exactly clear level
      send_sample(mk(0, 0, 0, 16'd7, 1, 1, 1, 1, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd8, 1, 1, 1, 1, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd9, 1, 1, 1, 1, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd10, 1, 1, 0, 0, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd11, 1, 1, 0, 0, 1, 1, 0));         // rearm edge
      send_sample(mk(32767, 32767, 32767, 16'd12, 0, 1, 0, 0, 0, 1, 0)); // invalid sample
      send_sample(mk(0, 0, 0, 16'd13, 1, 1, 1, 1, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd14, 1, 1, 1, 1, 0, 1, 1));
      send_sample(mk(0, 0, 0, 16'd15, 1, 1, 0, 0, 1, 0, 0));         // not ready
      send_sample(mk(0, 0, 0, 16'd16, 1, 1, 0, 0, 0, 1, 0));
      send_sample(mk(0, 0, 0, 16'd17, 1, 1, 0, 0, 1, 1, 0));
      send_sample(mk(-1000, 0, 0, 16'd18, 1, 1, 0, 0, 1, 1, 0));
      send_sample(mk(0, 0, 0, 16'd19, 1, 0, 0, 0, 1, 1, 0));

      apply_settings('{1'b1, 15'd1000, 15'd200, 16'd3, 16'd2, 16'd100, 16'd50, 16'd4});
      run_random(150);
      apply_settings('{1'b0, 15'd500, 15'd50, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0});
      run_random(20);

      send_idle_pct = 58;
      recv_idle_pct = 21;
      apply_settings('{1'b1, 15'd1, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
      run_random(80);
      // clear level below zero, blank window running past the phase range
      apply_settings('{1'b1, 15'd100, 15'd32766, 16'd2, 16'd1, 16'd65500, 16'd36, 16'd1});
      run_random(60);
      apply_settings('{1'b1, 15'd32767, 15'd32766, 16'd65535, 16'd65535, 16'd65535,
                       16'd65535, 16'd65535});
      run_random(40);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings('{1'b1, 15'd2000, 15'd500, 16'd1, 16'd0, 16'd40000, 16'd1000, 16'd2});
      run_random(150);

      wait_drained();
      // catch any result the block sends beyond the last one
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("overcurrent_fast_trip_unit_tb: clean");
      end else begin
         $display("overcurrent_fast_trip_unit_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
design/ocft_pkg.sv
design/ocft_phase_lane.sv
design/ocft_trip_ctrl.sv
design/overcurrent_fast_trip_unit.sv
tb/sv/ocft_trip_scoreboard.sv
tb/sv/overcurrent_fast_trip_unit_tb.sv
